// ----- design/srb_pkg.sv -----
`default_nettype none

package srb_pkg;

   // Field widths
   localparam int SEQ_W  = 32;
   localparam int BITS_W = 16;
   localparam int TAG_W  = 16;
   localparam int ACC_W  = 24;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_LIMIT = 1'b0;

   localparam logic [ACC_W-1:0] LIMIT_RESET = ACC_W'(128000 * 8);
   localparam logic [ACC_W-1:0] ACC_MAX     = {ACC_W{1'b1}};

   typedef enum logic [2:0] {
      OUT_DELIVER      = 3'd0,
      OUT_UNPARSED     = 3'd1,
      OUT_BUFFERED     = 3'd2,
      OUT_DUPLICATE    = 3'd3,
      OUT_OVERFLOW     = 3'd4,
      OUT_STALE        = 3'd5,
      OUT_CLOSE_ERR    = 3'd6,
      OUT_DEAD         = 3'd7
   } srb_outcome_type;

   // One held message in the window memory
   typedef struct packed {
      logic              close;
      logic [TAG_W-1:0]  tag;
      logic [BITS_W-1:0] bits;
   } srb_entry_type;

endpackage

`default_nettype wire

// ----- design/sequence_reorder_buffer_core.sv -----
`default_nettype none

// Receive-side reorder buffer for one reliable channel. Each req item is a
// message descriptor; the block answers with one or more rsp items, the
// final one marked by rsp_last. Unreliable or next-in-sequence messages are
// delivered at once, followed by any buffered successors in sequence order.
// Early reliable messages inside the window are held in a WINDOW_DEPTH-entry
// memory (slot = sequence mod WINDOW_DEPTH, tracked incrementally so no
// divider is needed); repeats are reported as duplicates and sequences
// outside the window as stale. Exceeding the bit limit (register at byte
// address 0) aborts the channel, and a close message ends it; after that
// every item is answered with the dead outcome until reset. An item is
// accepted in ST_IDLE, then evaluated and applied in ST_EVAL. Each drained
// message follows from ST_DRAIN, paced by the single registered read port
// of the window memory; a stalled rsp side holds the block in its state.
// Slot valid bits are flops cleared by reset, so no clearing pass is needed.
module sequence_reorder_buffer_core
   import srb_pkg::*;
#(
   parameter int WINDOW_DEPTH = 32
) (
   input  wire                    clock,
   input  wire                    reset,

   // Message descriptors in
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  [SEQ_W-1:0]       req_sequence_req,
   input  wire                    req_reliable,
   input  wire                    req_close,
   input  wire  [BITS_W-1:0]      req_msg_bits,
   input  wire  [TAG_W-1:0]       req_payload_tag,
   input  wire                    req_closing_locally,

   // Results out
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [2:0]             rsp_outcome,
   output logic [SEQ_W-1:0]       rsp_out_sequence,
   output logic [TAG_W-1:0]       rsp_out_tag,
   output logic                   rsp_out_close,
   output logic                   rsp_last,

   // Configuration
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire  [CSR_ADDR_W-1:0]  paddr,
   input  wire  [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam logic [SLOT_W:0]   DEPTH_S   = (SLOT_W+1)'(WINDOW_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
   localparam logic [SEQ_W-1:0]  DEPTH_SEQ = SEQ_W'(WINDOW_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DRAIN
   } state_type;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   // slot of sequence s + 1 given the slot of s; the sequence space wraps
   // to zero, which restarts the slot count
   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] slot,
                                                  input logic [SEQ_W-1:0]  s);
      return (s == '1) ? '0 : slot_inc(slot);
   endfunction

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type           state_ff, state_in;

   // latched item
   logic [SEQ_W-1:0]    in_seq_ff, in_seq_in;
   logic                in_rel_ff, in_rel_in;
   logic                in_close_ff, in_close_in;
   logic [BITS_W-1:0]   in_bits_ff, in_bits_in;
   logic [TAG_W-1:0]    in_tag_ff, in_tag_in;
   logic                in_unparsed_ff, in_unparsed_in;

   // channel state
   logic [SEQ_W-1:0]    last_seq_ff, last_seq_in;
   logic [SLOT_W-1:0]   last_slot_ff, last_slot_in;   // last_seq mod depth
   logic [WINDOW_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   logic [ACC_W-1:0]    buf_bits_ff, buf_bits_in;
   logic [CNT_W-1:0]    buf_count_ff, buf_count_in;
   logic                dead_ff, dead_in;
   logic [ACC_W-1:0]    limit_ff, limit_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   srb_outcome_type     outcome_ff, outcome_in;
   logic [SEQ_W-1:0]    out_seq_ff, out_seq_in;
   logic [TAG_W-1:0]    out_tag_ff, out_tag_in;
   logic                out_close_ff, out_close_in;
   logic                last_ff, last_in;

   // window memory
   srb_entry_type       mem [WINDOW_DEPTH];
   srb_entry_type       rd_data_ff;
   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   srb_entry_type       wr_data;

   // ---------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = outcome_ff;
   assign rsp_out_sequence = out_seq_ff;
   assign rsp_out_tag      = out_tag_ff;
   assign rsp_out_close    = out_close_ff;
   assign rsp_last         = last_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_LIMIT)
                   ? {{(CSR_DATA_W-ACC_W){1'b0}}, limit_ff} : '0;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      logic                out_free;
      logic [SEQ_W-1:0]    seq_gap;
      logic [SLOT_W:0]     slot_sum;
      logic [SLOT_W-1:0]   wslot;
      logic [ACC_W:0]      bits_sum;
      logic [ACC_W-1:0]    bits_sat;
      logic [SLOT_W-1:0]   nslot;
      logic [SEQ_W-1:0]    new_last;
      logic [SLOT_W-1:0]   dslot;
      logic [SEQ_W-1:0]    seq_next;
      logic [SLOT_W-1:0]   cur;
      logic [SLOT_W-1:0]   nxt;
      logic [ACC_W-1:0]    drain_bits;
      logic [CNT_W-1:0]    count_dec;
      srb_outcome_type     deliver;

      out_free = !rsp_valid_ff || rsp_ready;
      deliver  = in_unparsed_ff ? OUT_UNPARSED : OUT_DELIVER;

      // distance from the last in-order sequence; slot by wrap-add, except
      // when the window crosses zero, where the sequence is its own slot
      seq_gap  = in_seq_ff - last_seq_ff;
      slot_sum = {1'b0, last_slot_ff} + seq_gap[SLOT_W:0];
      wslot    = (in_seq_ff < last_seq_ff) ? in_seq_ff[SLOT_W-1:0]
                 : (slot_sum >= DEPTH_S) ? SLOT_W'(slot_sum - DEPTH_S)
                 : slot_sum[SLOT_W-1:0];
      bits_sum = {1'b0, buf_bits_ff} + {{(ACC_W+1-BITS_W){1'b0}}, in_bits_ff};
      bits_sat = bits_sum[ACC_W] ? ACC_MAX : bits_sum[ACC_W-1:0];
      nslot    = in_rel_ff ? slot_next(last_slot_ff, last_seq_ff) : last_slot_ff;
      new_last = in_rel_ff ? in_seq_ff : last_seq_ff;
      dslot    = slot_next(nslot, new_last);

      seq_next   = last_seq_ff + 1'b1;
      cur        = slot_next(last_slot_ff, last_seq_ff);
      nxt        = slot_next(cur, seq_next);
      drain_bits = (buf_bits_ff >= {{(ACC_W-BITS_W){1'b0}}, rd_data_ff.bits})
                   ? buf_bits_ff - {{(ACC_W-BITS_W){1'b0}}, rd_data_ff.bits}
                   : '0;
      count_dec  = (buf_count_ff != '0) ? buf_count_ff - 1'b1 : '0;

      state_in       = state_ff;
      in_seq_in      = in_seq_ff;
      in_rel_in      = in_rel_ff;
      in_close_in    = in_close_ff;
      in_bits_in     = in_bits_ff;
      in_tag_in      = in_tag_ff;
      in_unparsed_in = in_unparsed_ff;
      last_seq_in    = last_seq_ff;
      last_slot_in   = last_slot_ff;
      slot_valid_in  = slot_valid_ff;
      buf_bits_in    = buf_bits_ff;
      buf_count_in   = buf_count_ff;
      dead_in        = dead_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      outcome_in     = outcome_ff;
      out_seq_in     = out_seq_ff;
      out_tag_in     = out_tag_ff;
      out_close_in   = out_close_ff;
      last_in        = last_ff;
      rd_en          = 1'b0;
      rd_addr        = nxt;
      wr_en          = 1'b0;
      wr_addr        = wslot;
      wr_data        = '{close: in_close_ff, tag: in_tag_ff, bits: in_bits_ff};

      limit_in = (psel && penable && pwrite && pready &&
                  paddr[CSR_ADDR_W-1:2] == CSR_IDX_LIMIT)
                 ? pwdata[ACC_W-1:0] : limit_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_seq_in      = req_sequence_req;
               in_rel_in      = req_reliable;
               in_close_in    = req_close;
               in_bits_in     = req_msg_bits;
               in_tag_in      = req_payload_tag;
               in_unparsed_in = req_closing_locally;
               state_in       = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_seq_in   = in_seq_ff;
               out_tag_in   = in_tag_ff;
               out_close_in = in_close_ff;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
               if (dead_ff) begin
                  outcome_in = OUT_DEAD;
               end else if (in_rel_ff && seq_gap != SEQ_W'(1)) begin
                  if (seq_gap < SEQ_W'(2) || seq_gap > DEPTH_SEQ) begin
                     outcome_in = OUT_STALE;
                  end else if (slot_valid_ff[wslot]) begin
                     outcome_in = OUT_DUPLICATE;
                  end else begin
                     // early arrival: park it in the window
                     wr_en                = 1'b1;
                     slot_valid_in[wslot] = 1'b1;
                     buf_bits_in          = bits_sat;
                     buf_count_in         = buf_count_ff + 1'b1;
                     if (bits_sat > limit_ff) begin
                        dead_in    = 1'b1;
                        outcome_in = OUT_OVERFLOW;
                     end else begin
                        outcome_in = OUT_BUFFERED;
                     end
                  end
               end else begin
                  // in order or unreliable: deliver, then maybe drain
                  if (in_rel_ff) begin
                     last_seq_in = in_seq_ff;
                  end
                  last_slot_in = nslot;
                  if (in_close_ff) begin
                     dead_in    = 1'b1;
                     outcome_in = (buf_count_ff != '0) ? OUT_CLOSE_ERR : deliver;
                  end else begin
                     outcome_in = deliver;
                     if (slot_valid_ff[dslot]) begin
                        last_in  = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = dslot;
                        state_in = ST_DRAIN;
                     end
                  end
               end
            end
         end

         ST_DRAIN: begin
            // rd_data_ff holds the entry of slot cur
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               out_seq_in         = seq_next;
               out_tag_in         = rd_data_ff.tag;
               out_close_in       = rd_data_ff.close;
               slot_valid_in[cur] = 1'b0;
               buf_bits_in        = drain_bits;
               buf_count_in       = count_dec;
               last_seq_in        = seq_next;
               last_slot_in       = cur;
               last_in            = 1'b1;
               state_in           = ST_IDLE;
               if (rd_data_ff.close) begin
                  dead_in    = 1'b1;
                  outcome_in = (count_dec != '0) ? OUT_CLOSE_ERR : deliver;
               end else begin
                  outcome_in = deliver;
                  if (slot_valid_ff[nxt]) begin
                     last_in  = 1'b0;
                     rd_en    = 1'b1;
                     rd_addr  = nxt;
                     state_in = ST_DRAIN;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      in_seq_ff      <= in_seq_in;
      in_rel_ff      <= in_rel_in;
      in_close_ff    <= in_close_in;
      in_bits_ff     <= in_bits_in;
      in_tag_ff      <= in_tag_in;
      in_unparsed_ff <= in_unparsed_in;
      outcome_ff     <= outcome_in;
      out_seq_ff     <= out_seq_in;
      out_tag_ff     <= out_tag_in;
      out_close_ff   <= out_close_in;
      last_ff        <= last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_seq_ff   <= '0;
         last_slot_ff  <= '0;
         slot_valid_ff <= '0;
         buf_bits_ff   <= '0;
         buf_count_ff  <= '0;
         dead_ff       <= 1'b0;
         limit_ff      <= LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_seq_ff   <= last_seq_in;
         last_slot_ff  <= last_slot_in;
         slot_valid_ff <= slot_valid_in;
         buf_bits_ff   <= buf_bits_in;
         buf_count_ff  <= buf_count_in;
         dead_ff       <= dead_in;
         limit_ff      <= limit_in;
      end
   end

   // Window memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/srb_checker.sv -----
`default_nettype none

module srb_checker
   import srb_pkg::*;
(
   input wire              clock,
   input wire              reset,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input wire [2:0]        rsp_outcome,
   input wire [SEQ_W-1:0]  rsp_out_sequence,
   input wire [TAG_W-1:0]  rsp_out_tag,
   input wire              rsp_out_close,
   input wire              rsp_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) &&
      $stable(rsp_out_sequence) && $stable(rsp_out_tag) && $stable(rsp_last))
      else $error("rsp item changed while stalled");

   // outcomes that never start a drain are single results
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_BUFFERED || rsp_outcome == OUT_DUPLICATE ||
                    rsp_outcome == OUT_OVERFLOW || rsp_outcome == OUT_STALE ||
                    rsp_outcome == OUT_DEAD) |-> rsp_last)
      else $error("single-result outcome without last");

   // close ends the response train
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_close |-> rsp_last)
      else $error("close message not last");

   // close-pending error only reports a close message
   a_close_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_CLOSE_ERR |-> rsp_out_close)
      else $error("close error without close flag");

   // drained successors carry consecutive sequence numbers
   a_drain_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |->
      rsp_out_sequence == $past(rsp_out_sequence) + 1'b1 ||
      !$past(rsp_valid && rsp_ready) )
      else $error("drain sequence not consecutive");

endmodule

bind sequence_reorder_buffer_core srb_checker u_srb_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_outcome      (rsp_outcome),
   .rsp_out_sequence (rsp_out_sequence),
   .rsp_out_tag      (rsp_out_tag),
   .rsp_out_close    (rsp_out_close),
   .rsp_last         (rsp_last)
);

`default_nettype wire

// ----- sim/tb_sequence_reorder_buffer_core.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the reorder buffer. A scoreboard model tracks the
// window, the in-order pointer, the buffered-bit count and the dead flag,
// and predicts every rsp item for each accepted req item. Since the channel
// can only die once per reset, each run ends the channel in one randomly
// chosen way and then checks the dead outcome.
module tb_sequence_reorder_buffer_core;
   import srb_pkg::*;

   localparam int WIN            = 32;
   localparam int CLK_HALF       = 6;
   localparam int CSR_IDX_UNUSED = 1;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR  = CSR_ADDR_W'(4 * int'(CSR_IDX_LIMIT));
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4 * CSR_IDX_UNUSED);
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   // One message descriptor as driven on the req side
   typedef struct {
      logic [SEQ_W-1:0]  seq;
      logic              reliable;
      logic              close;
      logic [BITS_W-1:0] bits;
      logic [TAG_W-1:0]  tag;
      logic              unparsed;
   } message_type;

   // One rsp item as predicted
   typedef struct {
      srb_outcome_type   outcome;
      logic [SEQ_W-1:0]  seq;
      logic [TAG_W-1:0]  tag;
      logic              close;
      logic              last;
   } result_type;

   // DUT signals, all inputs known from time zero
   logic                  clock               = 1'b0;
   logic                  reset               = 1'b1;
   logic                  req_valid           = 1'b0;
   logic                  req_ready;
   logic [SEQ_W-1:0]      req_sequence_req    = '0;
   logic                  req_reliable        = 1'b0;
   logic                  req_close           = 1'b0;
   logic [BITS_W-1:0]     req_msg_bits        = '0;
   logic [TAG_W-1:0]      req_payload_tag     = '0;
   logic                  req_closing_locally = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready           = 1'b0;
   logic [2:0]            rsp_outcome;
   logic [SEQ_W-1:0]      rsp_out_sequence;
   logic [TAG_W-1:0]      rsp_out_tag;
   logic                  rsp_out_close;
   logic                  rsp_last;
   logic                  psel                = 1'b0;
   logic                  penable             = 1'b0;
   logic                  pwrite              = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr               = '0;
   logic [CSR_DATA_W-1:0] pwdata              = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Scoreboard copy of the channel state
   logic [SEQ_W-1:0]  in_order_seq;
   logic              held_valid [WIN];
   logic [BITS_W-1:0] held_bits  [WIN];
   logic [TAG_W-1:0]  held_tag   [WIN];
   logic              held_close [WIN];
   logic [ACC_W-1:0]  pending_bits;
   logic [5:0]        pending_count;
   logic              chan_dead;
   logic [ACC_W-1:0]  limit_bits;
   result_type        expected_results[$];

   // Run bookkeeping
   int         send_idle_pct   = 0;
   int         recv_stall_pct  = 0;
   int         error_count     = 0;
   int         items_sent      = 0;
   int         results_checked = 0;
   int         csr_accesses    = 0;
   string      end_name        = "nothing";
   result_type rsp_want;

   always #(CLK_HALF) clock = ~clock;

   sequence_reorder_buffer_core u_dut (.*);

   function automatic message_type mk_msg(input logic [SEQ_W-1:0] seq, input logic rel,
                                          input logic cl, input logic [BITS_W-1:0] bits,
                                          input logic [TAG_W-1:0] tag, input logic unparsed);
      message_type m;
      m.seq      = seq;
      m.reliable = rel;
      m.close    = cl;
      m.bits     = bits;
      m.tag      = tag;
      m.unparsed = unparsed;
      return m;
   endfunction

   function automatic result_type mk_result(input srb_outcome_type oc,
                                            input logic [SEQ_W-1:0] seq,
                                            input logic [TAG_W-1:0] tag, input logic cl);
      result_type r;
      r.outcome = oc;
      r.seq     = seq;
      r.tag     = tag;
      r.close   = cl;
      r.last    = 1'b0;
      return r;
   endfunction

   // Work out every rsp item one accepted message causes and queue them.
   task automatic predict_results(input message_type m);
      logic [SEQ_W-1:0] gap;
      logic [SEQ_W-1:0] nx;
      logic [ACC_W:0]   sum;
      srb_outcome_type  dlv;
      result_type       tail;
      int               slot;
      int               n;
      bit               done;
      dlv = m.unparsed ? OUT_UNPARSED : OUT_DELIVER;
      if (chan_dead) begin
         expected_results.push_back(mk_result(OUT_DEAD, m.seq, m.tag, m.close));
      end else begin
         gap = m.seq - in_order_seq;
         if (m.reliable && gap != 1) begin
            if (gap < 2 || gap > WIN) begin
               // stale or beyond the window, state untouched
               expected_results.push_back(mk_result(OUT_STALE, m.seq, m.tag, m.close));
            end else begin
               slot = int'(m.seq % WIN);
               if (held_valid[slot]) begin
                  expected_results.push_back(mk_result(OUT_DUPLICATE, m.seq, m.tag, m.close));
               end else begin
                  held_valid[slot] = 1'b1;
                  held_bits[slot]  = m.bits;
                  held_tag[slot]   = m.tag;
                  held_close[slot] = m.close;
                  sum = {1'b0, pending_bits} + m.bits;
                  pending_bits  = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
                  pending_count = pending_count + 6'd1;
                  if (pending_bits > limit_bits) begin
                     chan_dead = 1'b1;
                     expected_results.push_back(mk_result(OUT_OVERFLOW, m.seq, m.tag, m.close));
                  end else begin
                     expected_results.push_back(mk_result(OUT_BUFFERED, m.seq, m.tag, m.close));
                  end
               end
            end
         end else begin
            if (m.reliable) in_order_seq = m.seq;
            if (m.close) begin
               chan_dead = 1'b1;
               expected_results.push_back(mk_result(pending_count != 0 ? OUT_CLOSE_ERR : dlv,
                                                    m.seq, m.tag, 1'b1));
            end else begin
               expected_results.push_back(mk_result(dlv, m.seq, m.tag, 1'b0));
               // drain buffered successors in order
               n    = 1;
               done = 1'b0;
               while (!done && n < WIN + 1) begin
                  nx   = in_order_seq + 1;
                  slot = int'(nx % WIN);
                  if (!held_valid[slot]) begin
                     done = 1'b1;
                  end else begin
                     held_valid[slot] = 1'b0;
                     pending_bits  = (pending_bits >= held_bits[slot]) ?
                                     pending_bits - held_bits[slot] : '0;
                     pending_count = (pending_count != 0) ? pending_count - 6'd1 : '0;
                     in_order_seq  = nx;
                     if (held_close[slot]) begin
                        chan_dead = 1'b1;
                        expected_results.push_back(mk_result(pending_count != 0 ?
                                                             OUT_CLOSE_ERR : dlv,
                                                             nx, held_tag[slot], 1'b1));
                        done = 1'b1;
                     end else begin
                        expected_results.push_back(mk_result(dlv, nx, held_tag[slot], 1'b0));
                     end
                     n++;
                  end
               end
            end
         end
      end
      tail = expected_results.pop_back();
      tail.last = 1'b1;
      expected_results.push_back(tail);
   endtask

   // Entered in the time step of a rising edge; leaves req_valid high after
   // the accepting edge so back-to-back items need no extra assignment.
   task automatic send_msg(input message_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_sequence_req    <= m.seq;
      req_reliable        <= m.reliable;
      req_close           <= m.close;
      req_msg_bits        <= m.bits;
      req_payload_tag     <= m.tag;
      req_closing_locally <= m.unparsed;
      do @(posedge clock); while (!req_ready);
      predict_results(m);
      items_sent++;
   endtask

   // Random message for a live channel; never closes and never overflows.
   task automatic make_live_msg(output message_type m);
      logic [SEQ_W-1:0] gap;
      int               pick;
      int               d;
      int               k;
      pick       = $urandom_range(99);
      m.tag      = TAG_W'($urandom);
      m.unparsed = 1'($urandom_range(1));
      m.close    = 1'b0;
      m.reliable = 1'b1;
      case ($urandom_range(3))
         0:       m.bits = '0;
         1:       m.bits = '1;
         default: m.bits = BITS_W'($urandom);
      endcase
      if (pick < 20) begin
         d = 1;
      end else if (pick < 60) begin
         d = $urandom_range(2, WIN);
      end else begin
         // aim at an occupied slot to provoke a duplicate
         d = $urandom_range(2, WIN);
         for (k = 0; k < WIN - 1 && !held_valid[(in_order_seq + d) % WIN]; k++)
            d = (d == WIN) ? 2 : d + 1;
      end
      m.seq = in_order_seq + d;
      if (pick >= 72 && pick < 84) begin
         case ($urandom_range(3))
            0:       m.seq = in_order_seq;
            1:       m.seq = in_order_seq + $urandom_range(WIN + 1, WIN + 100);
            2:       m.seq = in_order_seq - $urandom_range(1, 100);
            default: m.seq = $urandom;
         endcase
      end else if (pick >= 84) begin
         m.reliable = 1'b0;
         m.seq      = $urandom;
      end
      // clip the size so a new buffer entry stays within the limit
      gap = m.seq - in_order_seq;
      if (m.reliable && gap >= 2 && gap <= WIN && !held_valid[m.seq % WIN] &&
          {1'b0, pending_bits} + m.bits > limit_bits)
         m.bits = BITS_W'(limit_bits - pending_bits);
   endtask

   // Fill every gap so the window ends up empty (needed before a lower limit).
   task automatic flush_window();
      while (pending_count != 0)
         send_msg(mk_msg(in_order_seq + 1, 1'b1, 1'b0, BITS_W'($urandom),
                         TAG_W'($urandom), 1'($urandom_range(1))));
   endtask

   // Lower req_valid, wait for the last rsp item, then let the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == LIMIT_ADDR) limit_bits = data[ACC_W-1:0];
      csr_accesses++;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) begin
         error_count++;
         $display("%0t: register read at %0d, expected %h got %h", $time, addr, want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      csr_accesses++;
      @(posedge clock);
   endtask

   // rsp side: random stalls and the in-order compare against the scoreboard
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, got outcome %0d seq %h tag %h",
                     $time, rsp_outcome, rsp_out_sequence, rsp_out_tag);
         end else begin
            rsp_want = expected_results.pop_front();
            if (rsp_outcome !== rsp_want.outcome || rsp_out_sequence !== rsp_want.seq ||
                rsp_out_tag !== rsp_want.tag || rsp_out_close !== rsp_want.close ||
                rsp_last !== rsp_want.last) begin
               error_count++;
               $display("%0t: result mismatch, expected outcome %0d seq %h tag %h close %b last %b",
                        $time, rsp_want.outcome, rsp_want.seq, rsp_want.tag, rsp_want.close,
                        rsp_want.last);
               $display("%0t:                  actual outcome %0d seq %h tag %h close %b last %b",
                        $time, rsp_outcome, rsp_out_sequence, rsp_out_tag, rsp_out_close,
                        rsp_last);
            end
         end
      end
   end

   task automatic test_reset_defaults();
      csr_read_check(LIMIT_ADDR, CSR_DATA_W'(LIMIT_RESET));
   endtask

   // In-order, unparsed and unreliable deliveries with extreme field values
   task automatic test_in_order_delivery();
      send_msg(mk_msg(1, 1'b1, 1'b0, '0, '0, 1'b0));
      send_msg(mk_msg(2, 1'b1, 1'b0, '1, '1, 1'b1));
      send_msg(mk_msg('1, 1'b0, 1'b0, 16'h5a5a, 16'h1234, 1'b0));
      send_msg(mk_msg(0, 1'b0, 1'b0, 16'ha5a5, 16'hedcb, 1'b1));
   endtask

   // Stale cases, window edges, duplicate and a drain of two
   task automatic test_window_handling();
      send_msg(mk_msg(in_order_seq, 1'b1, 1'b0, 16'd7, 16'h0001, 1'b0));
      send_msg(mk_msg(in_order_seq + WIN + 1, 1'b1, 1'b0, 16'd7, 16'h0002, 1'b0));
      send_msg(mk_msg(in_order_seq - 1, 1'b1, 1'b0, 16'd7, 16'h0003, 1'b1));
      send_msg(mk_msg(32'h8000_0000, 1'b1, 1'b0, '1, '1, 1'b0));
      send_msg(mk_msg(in_order_seq + WIN, 1'b1, 1'b0, '1, 16'h0020, 1'b0));
      send_msg(mk_msg(in_order_seq + 3, 1'b1, 1'b0, 16'd300, 16'h0033, 1'b0));
      send_msg(mk_msg(in_order_seq + 2, 1'b1, 1'b0, 16'd200, 16'h0022, 1'b1));
      send_msg(mk_msg(in_order_seq + 3, 1'b1, 1'b0, 16'd100, 16'h0bad, 1'b0));
      send_msg(mk_msg(in_order_seq + 1, 1'b1, 1'b0, 16'd1, 16'h0011, 1'b1));
      send_msg(mk_msg(32'h0000_ffff, 1'b0, 1'b0, 16'd5, 16'h7777, 1'b0));
   endtask

   // Register extremes, masking of the upper data bits, ignored index,
   // and buffering of an empty message at a zero limit
   task automatic test_config_registers();
      wait_idle();
      csr_write(LIMIT_ADDR, {8'ha5, ACC_MAX});
      csr_read_check(LIMIT_ADDR, CSR_DATA_W'(ACC_MAX));
      csr_write(UNUSED_ADDR, $urandom);
      csr_read_check(LIMIT_ADDR, CSR_DATA_W'(ACC_MAX));
      flush_window();
      wait_idle();
      csr_write(LIMIT_ADDR, '0);
      csr_read_check(LIMIT_ADDR, '0);
      send_msg(mk_msg(in_order_seq + 2, 1'b1, 1'b0, '0, 16'h4242, 1'b0));
      send_msg(mk_msg(in_order_seq + 1, 1'b1, 1'b0, '1, 16'h4141, 1'b0));
   endtask

   // Four idling phases, each under its own limit
   task automatic test_random_traffic();
      int          send_pct [4];
      int          recv_pct [4];
      int          ph;
      message_type m;
      send_pct = '{0, 87, 0, 34};
      recv_pct = '{0, 0, 87, 34};
      for (ph = 0; ph < 4; ph++) begin
         flush_window();
         wait_idle();
         case (ph)
            0:       csr_write(LIMIT_ADDR, CSR_DATA_W'(ACC_MAX));
            1:       csr_write(LIMIT_ADDR, $urandom);
            2:       csr_write(LIMIT_ADDR, $urandom_range(0, 200000));
            default: csr_write(LIMIT_ADDR, '0);
         endcase
         csr_read_check(LIMIT_ADDR, CSR_DATA_W'(limit_bits));
         send_idle_pct  = send_pct[ph];
         recv_stall_pct = recv_pct[ph];
         repeat (30) begin
            make_live_msg(m);
            send_msg(m);
         end
      end
   endtask

   // One way to end the channel, picked at random, then the dead outcome
   task automatic test_channel_end();
      logic [ACC_W-1:0] lim;
      int               mode;
      message_type      m;
      flush_window();
      wait_idle();
      mode = $urandom_range(3);
      lim  = (mode == 0) ? ACC_W'($urandom_range(0, 1000)) : ACC_MAX;
      csr_write(LIMIT_ADDR, CSR_DATA_W'(lim));
      case (mode)
         0: begin
            // exactly at the limit is still fine, one bit more aborts
            end_name = "overflow abort";
            send_msg(mk_msg(in_order_seq + 2, 1'b1, 1'b0, BITS_W'(lim), 16'hc0de, 1'b0));
            send_msg(mk_msg(in_order_seq + 3, 1'b1, 1'b0, BITS_W'($urandom_range(1, 65535)),
                            16'hdead, 1'b0));
         end
         1: begin
            end_name = "close with nothing pending";
            if ($urandom_range(1))
               send_msg(mk_msg(in_order_seq + 1, 1'b1, 1'b1, 16'd9, 16'hc105, 1'($urandom_range(1))));
            else
               send_msg(mk_msg($urandom, 1'b0, 1'b1, 16'd9, 16'hc106, 1'($urandom_range(1))));
         end
         2: begin
            end_name = "close with a message pending";
            send_msg(mk_msg(in_order_seq + 3, 1'b1, 1'b0, 16'd40, 16'h3333, 1'b0));
            send_msg(mk_msg(in_order_seq + 1, 1'b1, 1'b1, 16'd10, 16'h1111, 1'b0));
         end
         default: begin
            end_name = "close drained from the window";
            send_msg(mk_msg(in_order_seq + 2, 1'b1, 1'b1, 16'd20, 16'h2222, 1'b0));
            if ($urandom_range(1))
               send_msg(mk_msg(in_order_seq + 4, 1'b1, 1'b0, 16'd30, 16'h4444, 1'b0));
            send_msg(mk_msg(in_order_seq + 1, 1'b1, 1'b0, 16'd10, 16'h1111, 1'($urandom_range(1))));
         end
      endcase
      // any field values at all: the channel only answers dead now
      send_idle_pct  = 34;
      recv_stall_pct = 34;
      repeat (8) begin
         m = mk_msg($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    BITS_W'($urandom), TAG_W'($urandom), 1'($urandom_range(1)));
         send_msg(m);
      end
   endtask

   initial begin
      // scoreboard reset state
      in_order_seq  = '0;
      pending_bits  = '0;
      pending_count = '0;
      chan_dead     = 1'b0;
      limit_bits    = LIMIT_RESET;
      foreach (held_valid[i]) held_valid[i] = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_in_order_delivery();
      test_window_handling();
      test_config_registers();
      test_random_traffic();
      test_channel_end();

      // drain everything with the rsp side open, then watch for strays
      req_valid      <= 1'b0;
      recv_stall_pct = 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d message items, %0d checked results, %0d register accesses.",
               items_sent, results_checked, csr_accesses);
      $display("Four idling phases under several limits; channel ended by %s.", end_name);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule
